FILE: rtl/point_project_to_window_assert.svh
// Assertion macros used by the point projection control module.
`ifndef POINT_PROJECT_TO_WINDOW_ASSERT_SVH
`define POINT_PROJECT_TO_WINDOW_ASSERT_SVH
`define PPW_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPW_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`endif

FILE: rtl/ppw_pkg.sv
// ----------------------------------------------------------------------------
// ppw_pkg
// Types, constants and codes shared by the point projection modules.
// ----------------------------------------------------------------------------
package ppw_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CW = 32;
	localparam int NCOEF = 32;
	localparam int IW = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	localparam logic [1:0] REG_VP_X = 2'd0;
	localparam logic [1:0] REG_VP_Y = 2'd1;
	localparam logic [1:0] REG_VP_W = 2'd2;
	localparam logic [1:0] REG_VP_H = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_EYE,
		ST_CLIP,
		ST_WCHK,
		ST_DIV,
		ST_VIEW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic mac_eye;
		logic mac_clip;
		logic div_start;
		logic view;
		logic finish_zero;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic w_zero;
		logic div_busy;
		logic mac_last;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sh0_0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -68'sh0_0000_0000_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction
endpackage

FILE: rtl/ppw_if.sv
// ----------------------------------------------------------------------------
// ppw_in_if / ppw_out_if / ppw_cfg_if
// Valid-ready channels of the point projection block.
// ----------------------------------------------------------------------------
interface ppw_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [4:0] coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source(output valid, op, coef_index, coef_value, point_x, point_y, point_z,
		input ready);
	modport sink(input valid, op, coef_index, coef_value, point_x, point_y, point_z,
		output ready);
endinterface

interface ppw_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] win_x;
	logic signed [31:0] win_y;
	logic signed [31:0] win_z;
	logic valid_res;
	modport source(output valid, win_x, win_y, win_z, valid_res, input ready);
	modport sink(input valid, win_x, win_y, win_z, valid_res, output ready);
endinterface

interface ppw_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/ppw_ctrl.sv
// ----------------------------------------------------------------------------
// ppw_ctrl
// Sequencer for one request: table reads, multiply-accumulates, divide, scale.
// ----------------------------------------------------------------------------
`include "point_project_to_window_assert.svh"
module ppw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_op,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output ppw_pkg::cmd_t cmd,
	input ppw_pkg::sts_t sts
);
	ppw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ppw_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppw_pkg::ST_IDLE: begin
				if (in_valid && in_op == ppw_pkg::OP_PROJECT) state_d = ppw_pkg::ST_RD;
			end
			ppw_pkg::ST_RD: state_d = ppw_pkg::ST_EYE;
			ppw_pkg::ST_EYE: if (sts.mac_last) state_d = ppw_pkg::ST_CLIP;
			ppw_pkg::ST_CLIP: if (sts.mac_last) state_d = ppw_pkg::ST_WCHK;
			ppw_pkg::ST_WCHK: state_d = sts.w_zero ? ppw_pkg::ST_DONE : ppw_pkg::ST_DIV;
			ppw_pkg::ST_DIV: if (!sts.div_busy) state_d = ppw_pkg::ST_VIEW;
			ppw_pkg::ST_VIEW: state_d = ppw_pkg::ST_DONE;
			ppw_pkg::ST_DONE: if (out_ready) state_d = ppw_pkg::ST_IDLE;
			default: state_d = ppw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ppw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ppw_pkg::ST_RD: cmd.rd = 1'b1;
			ppw_pkg::ST_EYE: cmd.mac_eye = 1'b1;
			ppw_pkg::ST_CLIP: cmd.mac_clip = 1'b1;
			ppw_pkg::ST_WCHK: begin
				cmd.div_start = !sts.w_zero;
				cmd.finish_zero = sts.w_zero;
			end
			ppw_pkg::ST_DIV: cmd.view = !sts.div_busy;
			ppw_pkg::ST_VIEW: cmd.finish = 1'b1;
			ppw_pkg::ST_DONE: out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end

	`PPW_ASSERT_NEXT(a_done_holds, clk, arst_n, (out_valid && !out_ready), out_valid, "result dropped")
	`PPW_ASSERT_IMPL(a_excl, clk, arst_n, !(in_ready && out_valid), "accept while result pending")
	`PPW_ASSERT_NEXT(a_start, clk, arst_n, (in_valid && in_ready && in_op == ppw_pkg::OP_PROJECT), !in_ready, "projection not started")
endmodule

FILE: rtl/ppw_div.sv
// ----------------------------------------------------------------------------
// ppw_div
// Restoring divider, one quotient bit per cycle, three numerators in turn.
// ----------------------------------------------------------------------------
module ppw_div #(
	parameter int FRAC_BITS = ppw_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] num0,
	input logic signed [31:0] num1,
	input logic signed [31:0] num2,
	input logic signed [31:0] den,
	output logic busy,
	output logic signed [31:0] q0,
	output logic signed [31:0] q1,
	output logic signed [31:0] q2
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int BW = $clog2(NW);
	logic [NW-1:0] n_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [BW-1:0] bit_q;
	logic [1:0] sel_q;
	logic neg_q;
	logic [33:0] trial;
	logic [NW-1:0] qfin;
	logic signed [NW:0] qs;
	logic signed [31:0] res;

	always_comb begin
		trial = {r_q, n_q[NW-1]} - {2'b0, d_q};
		qfin = {n_q[NW-2:0], !trial[33]};
		qs = neg_q ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
		res = ppw_pkg::sat32(68'(qs));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			sel_q <= '0;
			bit_q <= '0;
			d_q <= '0;
			r_q <= '0;
			n_q <= '0;
			neg_q <= 1'b0;
			q0 <= '0;
			q1 <= '0;
			q2 <= '0;
		end else if (start) begin
			busy <= 1'b1;
			sel_q <= 2'd0;
			bit_q <= '0;
			d_q <= den[31] ? 32'(-den) : den;
			r_q <= '0;
			n_q <= ({{(NW-32){1'b0}}, (num0[31] ? 32'(-num0) : num0)} << FRAC_BITS);
			neg_q <= num0[31] ^ den[31];
		end else if (busy) begin
			if (bit_q == BW'(NW-1)) begin
				case (sel_q)
					2'd0: q0 <= res;
					2'd1: q1 <= res;
					default: q2 <= res;
				endcase
				bit_q <= '0;
				r_q <= '0;
				if (sel_q == 2'd2) busy <= 1'b0;
				else begin
					sel_q <= sel_q + 2'd1;
					n_q <= (sel_q == 2'd0) ?
						({{(NW-32){1'b0}}, (num1[31] ? 32'(-num1) : num1)} << FRAC_BITS) :
						({{(NW-32){1'b0}}, (num2[31] ? 32'(-num2) : num2)} << FRAC_BITS);
					neg_q <= ((sel_q == 2'd0) ? num1[31] : num2[31]) ^ den[31];
				end
			end else begin
				bit_q <= bit_q + 1'b1;
				r_q <= trial[33] ? {r_q[31:0], n_q[NW-1]} : trial[32:0];
				n_q <= qfin;
			end
		end
	end
endmodule

FILE: rtl/ppw_dp.sv
// ----------------------------------------------------------------------------
// ppw_dp
// Coefficient memory, shared multiply-accumulate unit and viewport scaling.
// ----------------------------------------------------------------------------
module ppw_dp #(
	parameter int FRAC_BITS = ppw_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input ppw_pkg::cmd_t cmd,
	output ppw_pkg::sts_t sts,
	input logic in_acc,
	input logic in_op,
	input logic [4:0] coef_index,
	input logic signed [31:0] coef_value,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	input logic signed [15:0] vp_x,
	input logic signed [15:0] vp_y,
	input logic [15:0] vp_w,
	input logic [15:0] vp_h,
	output logic signed [31:0] win_x,
	output logic signed [31:0] win_y,
	output logic signed [31:0] win_z,
	output logic valid_res
);
	logic [31:0] mem [ppw_pkg::NCOEF];
	logic signed [31:0] rdata_q;
	logic [4:0] raddr;
	logic signed [31:0] p_q [3];
	logic signed [31:0] eye_q [4];
	logic signed [31:0] clip_q [3];
	logic signed [67:0] acc_q;
	logic [1:0] r_q, k_q;
	logic signed [31:0] opnd;
	logic signed [63:0] prod;
	logic signed [67:0] term;
	logic signed [31:0] w;
	logic dbusy;
	logic signed [31:0] nd0, nd1, nd2;
	logic signed [67:0] wx, wy, wz;
	logic eye_ph;

	assign eye_ph = cmd.mac_eye;
	// Address of the coefficient needed on the following cycle.
	always_comb begin
		logic [1:0] rn, kn;
		rn = r_q; kn = k_q;
		if (cmd.rd) begin rn = 2'd0; kn = 2'd0; end
		else if (eye_ph || cmd.mac_clip) begin
			if (kn == 2'd3) begin kn = 2'd0; rn = rn + 2'd1; end
			else kn = kn + 2'd1;
		end
		if (eye_ph && r_q == 2'd3 && k_q == 2'd3) raddr = {3'b100, 2'd0};
		else if (cmd.mac_clip) raddr = {1'b1, kn, rn};
		else if (cmd.rd) raddr = 5'd0;
		else raddr = {1'b0, kn, rn};
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_op == ppw_pkg::OP_WRITE) mem[coef_index] <= coef_value;
		rdata_q <= mem[raddr];
	end

	// Eye pass: k 0..2 are products, k 3 adds the translation entry unshifted.
	always_comb begin
		if (eye_ph) opnd = (k_q == 2'd3) ? 32'sd0 : p_q[k_q];
		else opnd = eye_q[k_q];
		prod = rdata_q * opnd;
		if (eye_ph && k_q == 2'd3) term = 68'(rdata_q);
		else term = 68'(prod >>> FRAC_BITS);
	end

	assign sts.mac_last = (r_q == (eye_ph ? 2'd3 : 2'd2)) && k_q == 2'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0; k_q <= '0;
		end else if (cmd.rd) begin
			r_q <= '0; k_q <= '0;
		end else if (cmd.mac_eye || cmd.mac_clip) begin
			if (sts.mac_last) begin r_q <= '0; k_q <= '0; end
			else if (k_q == 2'd3) begin k_q <= '0; r_q <= r_q + 2'd1; end
			else k_q <= k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q[0] <= point_x; p_q[1] <= point_y; p_q[2] <= point_z;
		end
		if (cmd.rd) acc_q <= '0;
		else if (cmd.mac_eye || cmd.mac_clip) begin
			if (k_q == 2'd3) begin
				acc_q <= '0;
				if (eye_ph) eye_q[r_q] <= ppw_pkg::sat32(acc_q + term);
				else clip_q[r_q] <= ppw_pkg::sat32(acc_q + term);
			end else acc_q <= acc_q + term;
		end
	end

	assign w = ppw_pkg::sat32(-68'(eye_q[2]));
	assign sts.w_zero = (w == 32'sd0);
	assign sts.div_busy = dbusy;

	ppw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num0(clip_q[0]), .num1(clip_q[1]), .num2(clip_q[2]), .den(w),
		.busy(dbusy), .q0(nd0), .q1(nd1), .q2(nd2)
	);

	always_comb begin
		wx = (((68'(nd0) + (68'sd1 <<< FRAC_BITS)) * $signed({1'b0, vp_w})) >>> 1)
			+ (68'(vp_x) <<< FRAC_BITS);
		wy = (((68'(nd1) + (68'sd1 <<< FRAC_BITS)) * $signed({1'b0, vp_h})) >>> 1)
			+ (68'(vp_y) <<< FRAC_BITS);
		wz = (68'(nd2) + (68'sd1 <<< FRAC_BITS)) >>> 1;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_zero) begin
			win_x <= '0; win_y <= '0; win_z <= '0; valid_res <= 1'b0;
		end else if (cmd.view) begin
			win_x <= ppw_pkg::sat32(wx);
			win_y <= ppw_pkg::sat32(wy);
			win_z <= ppw_pkg::sat32(wz);
			valid_res <= 1'b1;
		end
	end
endmodule

FILE: rtl/point_project_to_window.sv
// ----------------------------------------------------------------------------
// point_project_to_window
// Fixed-point projection of object points to window coordinates.
// ----------------------------------------------------------------------------
// A coefficient write gives no result. A projection holds off further requests
// until its result has been taken. After a request is accepted the block reads
// the first coefficient, runs the eye and clip multiply-accumulates on the one
// shared multiplier, checks w, then runs three divides on the one-bit-per-cycle
// divider and scales the quotients to the viewport. When w is zero the divides
// and scaling are skipped. The block passes through idle between a taken result
// and the next accepted request.
module point_project_to_window #(
	parameter int FRAC_BITS = ppw_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	ppw_in_if.sink in_ch,
	ppw_out_if.source out_ch,
	ppw_cfg_if.sink cfg
);
	ppw_pkg::cmd_t cmd;
	ppw_pkg::sts_t sts;
	logic signed [15:0] vp_x_q, vp_y_q;
	logic [15:0] vp_w_q, vp_h_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_x_q <= '0; vp_y_q <= '0; vp_w_q <= '0; vp_h_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				ppw_pkg::REG_VP_X: vp_x_q <= cfg.data;
				ppw_pkg::REG_VP_Y: vp_y_q <= cfg.data;
				ppw_pkg::REG_VP_W: vp_w_q <= cfg.data;
				ppw_pkg::REG_VP_H: vp_h_q <= cfg.data;
				default: vp_x_q <= vp_x_q;
			endcase
		end
	end

	ppw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_op(in_ch.op),
		.in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	ppw_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_acc(in_ch.valid && in_ch.ready), .in_op(in_ch.op),
		.coef_index(in_ch.coef_index), .coef_value(in_ch.coef_value),
		.point_x(in_ch.point_x), .point_y(in_ch.point_y), .point_z(in_ch.point_z),
		.vp_x(vp_x_q), .vp_y(vp_y_q), .vp_w(vp_w_q), .vp_h(vp_h_q),
		.win_x(out_ch.win_x), .win_y(out_ch.win_y), .win_z(out_ch.win_z),
		.valid_res(out_ch.valid_res)
	);
endmodule
